// ===== sv/tlpq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the three-level priority queue table.
// No dependencies; used by tlpq_ctrl and the top level.
package tlpq_pkg;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_CALL   = 2'd1,
        REQ_FIND   = 2'd2,
        REQ_UPDATE = 2'd3
    } req_kind_t;

    typedef enum logic [2:0] {
        RSP_ADDED      = 3'd0,
        RSP_ENTRY      = 3'd1,
        RSP_EMPTY      = 3'd2,
        RSP_NOT_FOUND  = 3'd3,
        RSP_NO_CURRENT = 3'd4,
        RSP_FULL       = 3'd5
    } rsp_code_t;

    localparam logic [1:0] ST_WAITING    = 2'd0;
    localparam logic [1:0] ST_IN_SERVICE = 2'd1;
    localparam logic [1:0] ST_DONE       = 2'd2;

    localparam logic [1:0] PRI_EMERGENCY = 2'd1;
    localparam logic [1:0] PRI_ELDERLY   = 2'd2;
    localparam logic [1:0] PRI_GENERAL   = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_UPD,
        S_SHIFT,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [15:0] id;
        logic [1:0]  pri;
        logic [7:0]  service;
        logic [15:0] ticket;
        logic [15:0] arrival;
        logic [1:0]  status;
    } entry_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [1:0]  priority_class;
        logic [15:0] patient_id;
        logic [7:0]  service_code;
        logic [15:0] ticket_number;
        logic [15:0] arrival_time;
        logic [1:0]  new_status;
    } req_t;

    typedef struct packed {
        logic [2:0] code;
        logic [5:0] index;
        entry_t     entry;
    } rsp_t;

endpackage

// ===== sv/tlpq_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tlpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/tlpq_ctrl.sv =====
`timescale 1ns / 1ps
// Request sequencer: adds, scans, picks, updates, compacts the RAM entry table.
// Depends on tlpq_pkg; drives one tlpq_ram instance through its ports.
module tlpq_ctrl #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  tlpq_pkg::req_t       req,
    output logic                 busy,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output tlpq_pkg::rsp_t       rsp,
    output logic                 ram_we,
    output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] ram_waddr,
    output tlpq_pkg::entry_t     ram_wdata,
    output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] ram_raddr,
    input  tlpq_pkg::entry_t     ram_rdata
);
    import tlpq_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    state_t             state_reg, state_next;
    req_t               req_reg, req_next;
    rsp_t               rsp_reg, rsp_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               cur_valid_reg, cur_valid_next;
    logic [IDX_W-1:0]   cur_idx_reg, cur_idx_next;
    logic [CNT_W-1:0]   addr_reg, addr_next;
    logic               pend_reg, pend_next;
    logic [IDX_W-1:0]   pend_idx_reg, pend_idx_next;
    logic               f2_valid_reg, f2_valid_next;
    logic [IDX_W-1:0]   f2_idx_reg, f2_idx_next;
    logic               f3_valid_reg, f3_valid_next;
    logic [IDX_W-1:0]   f3_idx_reg, f3_idx_next;
    logic [IDX_W-1:0]   shift_idx_reg, shift_idx_next;

    logic               issue;
    logic               hit;
    logic [CNT_W-1:0]   next_pos;
    logic [CNT_W:0]     after_next;
    entry_t             new_entry;
    entry_t             upd_entry;

    function automatic rsp_t entry_rsp(input rsp_code_t code, input logic [IDX_W-1:0] pos,
                                       input entry_t e);
        rsp_t r;
        r.code  = code;
        r.index = 6'(pos);
        r.entry = e;
        return r;
    endfunction

    function automatic rsp_t none_rsp(input rsp_code_t code);
        rsp_t r;
        r      = '0;
        r.code = code;
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            cur_valid_reg <= 1'b0;
            cur_idx_reg   <= '0;
            pend_reg      <= 1'b0;
            f2_valid_reg  <= 1'b0;
            f3_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            cur_valid_reg <= cur_valid_next;
            cur_idx_reg   <= cur_idx_next;
            pend_reg      <= pend_next;
            f2_valid_reg  <= f2_valid_next;
            f3_valid_reg  <= f3_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        rsp_reg       <= rsp_next;
        addr_reg      <= addr_next;
        pend_idx_reg  <= pend_idx_next;
        f2_idx_reg    <= f2_idx_next;
        f3_idx_reg    <= f3_idx_next;
        shift_idx_reg <= shift_idx_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        rsp_next       = rsp_reg;
        cnt_next       = cnt_reg;
        cur_valid_next = cur_valid_reg;
        cur_idx_next   = cur_idx_reg;
        addr_next      = addr_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        f2_valid_next  = f2_valid_reg;
        f2_idx_next    = f2_idx_reg;
        f3_valid_next  = f3_valid_reg;
        f3_idx_next    = f3_idx_reg;
        shift_idx_next = shift_idx_reg;

        busy      = (state_reg != S_IDLE);
        rsp_valid = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = cnt_reg[IDX_W-1:0];
        ram_wdata = '0;
        ram_raddr = addr_reg[IDX_W-1:0];

        issue      = (addr_reg < cnt_reg);
        hit        = 1'b0;
        next_pos   = CNT_W'(cur_idx_reg) + CNT_W'(1);
        after_next = (CNT_W + 1)'(shift_idx_reg) + (CNT_W + 1)'(2);

        new_entry.id      = req.patient_id;
        new_entry.pri     = req.priority_class;
        new_entry.service = req.service_code;
        new_entry.ticket  = req.ticket_number;
        new_entry.arrival = req.arrival_time;
        new_entry.status  = ST_WAITING;

        upd_entry        = ram_rdata;
        upd_entry.status = req_reg.new_status;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req;
                    case (req.req_type)
                        REQ_ADD:
                        begin
                            if (cnt_reg == CNT_W'(TABLE_DEPTH))
                            begin
                                rsp_next = none_rsp(RSP_FULL);
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = cnt_reg[IDX_W-1:0];
                                ram_wdata = new_entry;
                                cnt_next  = cnt_reg + CNT_W'(1);
                                rsp_next  = entry_rsp(RSP_ADDED, cnt_reg[IDX_W-1:0], new_entry);
                            end
                            state_next = S_RESP;
                        end
                        REQ_CALL, REQ_FIND:
                        begin
                            addr_next     = '0;
                            pend_next     = 1'b0;
                            f2_valid_next = 1'b0;
                            f3_valid_next = 1'b0;
                            state_next    = S_SCAN;
                        end
                        default:
                        begin
                            if (!cur_valid_reg || (CNT_W'(cur_idx_reg) >= cnt_reg))
                            begin
                                rsp_next   = none_rsp(RSP_NO_CURRENT);
                                state_next = S_RESP;
                            end
                            else
                            begin
                                ram_raddr  = cur_idx_reg;
                                state_next = S_UPD;
                            end
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // Examine the entry read last cycle.
                if (pend_reg)
                begin
                    if (req_reg.req_type == REQ_FIND)
                    begin
                        hit = (ram_rdata.id == req_reg.patient_id);
                    end
                    else if (ram_rdata.pri == PRI_EMERGENCY)
                    begin
                        hit = 1'b1;
                    end
                    else if (ram_rdata.pri == PRI_ELDERLY && !f2_valid_reg)
                    begin
                        f2_valid_next = 1'b1;
                        f2_idx_next   = pend_idx_reg;
                    end
                    else if (ram_rdata.pri == PRI_GENERAL && !f3_valid_reg)
                    begin
                        f3_valid_next = 1'b1;
                        f3_idx_next   = pend_idx_reg;
                    end
                end

                if (hit)
                begin
                    pend_next = 1'b0;
                    rsp_next  = entry_rsp(RSP_ENTRY, pend_idx_reg, ram_rdata);
                    if (req_reg.req_type == REQ_CALL)
                    begin
                        cur_valid_next = 1'b1;
                        cur_idx_next   = pend_idx_reg;
                    end
                    state_next = S_RESP;
                end
                else if (!issue)
                begin
                    pend_next = 1'b0;
                    if (req_reg.req_type == REQ_FIND)
                    begin
                        rsp_next   = none_rsp(RSP_NOT_FOUND);
                        state_next = S_RESP;
                    end
                    else if (f2_valid_next)
                    begin
                        ram_raddr     = f2_idx_next;
                        pend_idx_next = f2_idx_next;
                        state_next    = S_PICK;
                    end
                    else if (f3_valid_next)
                    begin
                        ram_raddr     = f3_idx_next;
                        pend_idx_next = f3_idx_next;
                        state_next    = S_PICK;
                    end
                    else
                    begin
                        cur_valid_next = 1'b0;
                        cur_idx_next   = '0;
                        rsp_next       = none_rsp(RSP_EMPTY);
                        state_next     = S_RESP;
                    end
                end
                else
                begin
                    addr_next     = addr_reg + CNT_W'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = addr_reg[IDX_W-1:0];
                end
            end

            S_PICK:
            begin
                rsp_next       = entry_rsp(RSP_ENTRY, pend_idx_reg, ram_rdata);
                cur_valid_next = 1'b1;
                cur_idx_next   = pend_idx_reg;
                state_next     = S_RESP;
            end

            S_UPD:
            begin
                case (req_reg.new_status)
                    ST_WAITING, ST_IN_SERVICE:
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = cur_idx_reg;
                        ram_wdata  = upd_entry;
                        rsp_next   = entry_rsp(RSP_ENTRY, cur_idx_reg, upd_entry);
                        state_next = S_RESP;
                    end
                    ST_DONE:
                    begin
                        rsp_next       = entry_rsp(RSP_ENTRY, cur_idx_reg, upd_entry);
                        cur_valid_next = 1'b0;
                        cur_idx_next   = '0;
                        if (next_pos < cnt_reg)
                        begin
                            ram_raddr      = IDX_W'(next_pos);
                            shift_idx_next = cur_idx_reg;
                            state_next     = S_SHIFT;
                        end
                        else
                        begin
                            cnt_next   = cnt_reg - CNT_W'(1);
                            state_next = S_RESP;
                        end
                    end
                    default:
                    begin
                        rsp_next   = entry_rsp(RSP_ENTRY, cur_idx_reg, ram_rdata);
                        state_next = S_RESP;
                    end
                endcase
            end

            S_SHIFT:
            begin
                // Move the entry above down one slot, fetch the one after it.
                ram_we    = 1'b1;
                ram_waddr = shift_idx_reg;
                ram_wdata = ram_rdata;
                if (after_next < (CNT_W + 1)'(cnt_reg))
                begin
                    ram_raddr      = IDX_W'(after_next);
                    shift_idx_next = shift_idx_reg + IDX_W'(1);
                end
                else
                begin
                    cnt_next   = cnt_reg - CNT_W'(1);
                    state_next = S_RESP;
                end
            end

            S_RESP:
            begin
                rsp_valid = 1'b1;
                if (rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp = rsp_reg;

endmodule

// ===== sv/three_level_priority_queue_table_core.sv =====
`timescale 1ns / 1ps
// Top level of the three-level priority queue table: input capture, output register.
// Depends on tlpq_pkg, tlpq_ctrl and tlpq_ram.
//
//  channel | handshake             | payload
//  --------+-----------------------+--------------------------------------------------
//  in      | in_valid / in_stall   | req_type, priority_class, patient_id, service_code,
//          |                       | ticket_number, arrival_time, new_status
//  out     | out_valid / out_stall | resp_code, entry_index, out_id, out_priority,
//          |                       | out_service, out_ticket, out_arrival, out_status
//
// Add, full table and update without current need no scan; a status update writes the
// entry back; find scans the table, call-next scans it and may read the pick; done
// shifts any later entries down one slot. The entry RAM's single read port reads one
// entry a cycle in scans and shifts. Reset clears the state, the count and the current
// pointer; the RAM is never cleared. in_stall stays high until the result is handed to
// the output register, which holds it while out_stall is high and frees the sequencer.
module three_level_priority_queue_table_core #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [1:0]  priority_class,
    input  logic [15:0] patient_id,
    input  logic [7:0]  service_code,
    input  logic [15:0] ticket_number,
    input  logic [15:0] arrival_time,
    input  logic [1:0]  new_status,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  resp_code,
    output logic [5:0]  entry_index,
    output logic [15:0] out_id,
    output logic [1:0]  out_priority,
    output logic [7:0]  out_service,
    output logic [15:0] out_ticket,
    output logic [15:0] out_arrival,
    output logic [1:0]  out_status
);
    import tlpq_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    req_t             req;
    rsp_t             rsp;
    logic             busy;
    logic             rsp_valid;
    logic             rsp_ready;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [IDX_W-1:0] ram_raddr;
    entry_t           ram_wdata;
    entry_t           ram_rdata;

    logic             out_valid_reg, out_valid_next;
    rsp_t             out_reg, out_next;

    // Bundle the input beat for the sequencer.
    assign req.req_type       = req_type;
    assign req.priority_class = priority_class;
    assign req.patient_id     = patient_id;
    assign req.service_code   = service_code;
    assign req.ticket_number  = ticket_number;
    assign req.arrival_time   = arrival_time;
    assign req.new_status     = new_status;

    // Accept only while the sequencer is idle.
    assign in_stall = busy;

    tlpq_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (in_valid),
        .req       (req),
        .busy      (busy),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    tlpq_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output register: load when empty or draining this cycle, hold while stalled.
    assign rsp_ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (rsp_valid && rsp_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = rsp;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid    = out_valid_reg;
    assign resp_code    = out_reg.code;
    assign entry_index  = out_reg.index;
    assign out_id       = out_reg.entry.id;
    assign out_priority = out_reg.entry.pri;
    assign out_service  = out_reg.entry.service;
    assign out_ticket   = out_reg.entry.ticket;
    assign out_arrival  = out_reg.entry.arrival;
    assign out_status   = out_reg.entry.status;

endmodule
